// ----- hdl/awbs_pkg.sv -----
// ----------------------------------------------------------------------------
// awbs_pkg
// shared types and codes for the adaptive weighted bin selector
// ----------------------------------------------------------------------------
`default_nettype none

package awbs_pkg;

    // width of the random draw field
    localparam int RAND_W = 8;

    // operation codes carried in the func field
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the input transaction, clear the walk
        logic load;      // read the named bin and form the move limit
        logic step;      // visit one bin of the walk
        logic wrback;    // store the named bin's new weight
        logic fin;       // move the result into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_select; // latched transaction is a select
        logic idx_ok;    // named bin exists
        logic last;      // walk counter sits on the last bin
        logic out_free;  // output register can take a result this cycle
    } t_stat;

endpackage

`default_nettype wire

// ----- hdl/adaptive_weighted_bin_selector.sv -----
// ----------------------------------------------------------------------------
// adaptive_weighted_bin_selector
// learning-automaton weight table with roulette-wheel bin selection
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready carry one transaction of i_func,
//   i_bin_index, i_improved and i_rand_value
// output channel: o_valid / i_ready carry one result transaction of
//   o_chosen_bin and o_bin_weight for every input transaction
// update (func 0): the named bin gains one unit from each other nonzero bin
//   on reward, or gives one unit to each other bin below full on penalty,
//   at most NUM_BINS-1 units; the result is the bin and its new weight
// select (func 1): first bin whose prefix sum reaches i_rand_value, or the
//   last bin when none does; the result is that bin and its weight
// timing: one bin of the weight table is visited per cycle by a single
//   read port; an update passes the load, walk, write back and hand-off
//   states, a select skips the write back state; o_ready returns in the
//   cycle after the hand-off
// reset: synchronous, active low; every weight returns to
//   TOTAL_WEIGHT/NUM_BINS with any remainder in the last bin, no result
//   is pending
// stall: a finished result waits in the output register; new input is
//   taken meanwhile, and the next result holds until the register frees
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_weighted_bin_selector #(
    parameter  int NUM_BINS     = 8,
    parameter  int TOTAL_WEIGHT = 256,
    localparam int BIN_W        = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1,
    localparam int WEIGHT_W     = $clog2(TOTAL_WEIGHT + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input transaction
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_func,
    input  wire logic [BIN_W-1:0]            i_bin_index,
    input  wire logic                        i_improved,
    input  wire logic [awbs_pkg::RAND_W-1:0] i_rand_value,
    // result transaction
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [BIN_W-1:0]                 o_chosen_bin,
    output logic [WEIGHT_W-1:0]              o_bin_weight
);

    awbs_pkg::t_cmd  cmd;
    awbs_pkg::t_stat stat;

    // sequencer: idle, load named bin, walk all bins, write back, hand off
    awbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // weight table, walk arithmetic and output register
    awbs_dp #(
        .NUM_BINS     (NUM_BINS),
        .TOTAL_WEIGHT (TOTAL_WEIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_func),
        .i_bin_index  (i_bin_index),
        .i_improved   (i_improved),
        .i_rand_value (i_rand_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_chosen_bin (o_chosen_bin),
        .o_bin_weight (o_bin_weight)
    );

endmodule

`default_nettype wire

// ----- hdl/awbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// awbs_ctrl
// sequencer: accept, load, walk over the bins, write back, hand off result
// ----------------------------------------------------------------------------
`default_nettype none

module awbs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire awbs_pkg::t_stat i_stat,
    output awbs_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_WALK = 5'b00100,
        S_WB   = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_ready       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!i_stat.is_select && !i_stat.idx_ok) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.load = !i_stat.is_select;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_stat.last) begin
                    n_state = i_stat.is_select ? S_FIN : S_WB;
                end
            end
            S_WB: begin
                o_cmd.wrback = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a new transaction taken at rest always moves the sequencer to the load step
    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_LOAD))
        else $error("capture did not start the load step");

    // the write back always follows the last step of an update walk
    a_wb_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wrback |-> $past(o_cmd.step) && $past(i_stat.last))
        else $error("write back without a finished walk");

    // the result is only handed off when the output register is free
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> i_stat.out_free)
        else $error("result handed off into a busy output register");
`endif

endmodule

`default_nettype wire

// ----- hdl/awbs_dp.sv -----
// ----------------------------------------------------------------------------
// awbs_dp
// weight table, move and prefix-sum walk, output register
// ----------------------------------------------------------------------------
`default_nettype none

module awbs_dp #(
    parameter  int NUM_BINS     = 8,
    parameter  int TOTAL_WEIGHT = 256,
    localparam int BIN_W        = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1,
    localparam int WEIGHT_W     = $clog2(TOTAL_WEIGHT + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire awbs_pkg::t_cmd            i_cmd,
    output awbs_pkg::t_stat                o_stat,
    input  wire logic                      i_func,
    input  wire logic [BIN_W-1:0]          i_bin_index,
    input  wire logic                      i_improved,
    input  wire logic [awbs_pkg::RAND_W-1:0] i_rand_value,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [BIN_W-1:0]               o_chosen_bin,
    output logic [WEIGHT_W-1:0]            o_bin_weight
);

    localparam int CMP_W = (WEIGHT_W > awbs_pkg::RAND_W) ? WEIGHT_W : awbs_pkg::RAND_W;
    localparam int SHARE = TOTAL_WEIGHT / NUM_BINS;
    localparam int LAST_SHARE = SHARE + TOTAL_WEIGHT - SHARE * NUM_BINS;
    localparam logic [WEIGHT_W-1:0] SHARE_W      = WEIGHT_W'(SHARE);
    localparam logic [WEIGHT_W-1:0] LAST_SHARE_W = WEIGHT_W'(LAST_SHARE);
    localparam logic [WEIGHT_W-1:0] TOTAL_W      = WEIGHT_W'(TOTAL_WEIGHT);
    localparam logic [WEIGHT_W-1:0] FULL_W       = WEIGHT_W'(TOTAL_WEIGHT - 1);
    localparam logic [WEIGHT_W-1:0] MAX_MOVE_W   = WEIGHT_W'(NUM_BINS - 1);
    localparam logic [BIN_W-1:0]    MAX_MOVE_B   = BIN_W'(NUM_BINS - 1);
    localparam logic [BIN_W-1:0]    LAST_BIN     = BIN_W'(NUM_BINS - 1);
    localparam logic [BIN_W:0]      NUM_BINS_X   = (BIN_W + 1)'(NUM_BINS);

    logic [WEIGHT_W-1:0] r_w [NUM_BINS];

    logic                        r_func;
    logic [BIN_W-1:0]            r_idx;
    logic                        r_improved;
    logic [awbs_pkg::RAND_W-1:0] r_rand;
    logic [WEIGHT_W-1:0]         r_own;
    logic [BIN_W-1:0]            r_limit;
    logic [BIN_W-1:0]            r_moved;
    logic [BIN_W-1:0]            r_cnt;
    logic [WEIGHT_W-1:0]         r_cum;
    logic                        r_found;
    logic [BIN_W-1:0]            r_res_bin;
    logic [WEIGHT_W-1:0]         r_res_wt;
    logic                        r_out_valid;
    logic [BIN_W-1:0]            r_out_bin;
    logic [WEIGHT_W-1:0]         r_out_wt;

    logic                        idx_ok;
    logic [BIN_W-1:0]            rd_addr;
    logic [WEIGHT_W-1:0]         rd_data;
    logic [WEIGHT_W-1:0]         gap;
    logic [WEIGHT_W-1:0]         lim_src;
    logic [WEIGHT_W-1:0]         n_cum;
    logic                        hit;
    logic                        do_move;
    logic                        wr_en;
    logic [BIN_W-1:0]            wr_addr;
    logic [WEIGHT_W-1:0]         wr_data;

    assign idx_ok  = ({1'b0, r_idx} < NUM_BINS_X);
    assign rd_addr = i_cmd.load ? (idx_ok ? r_idx : '0) : r_cnt;
    assign rd_data = r_w[rd_addr];

    // move limit from the named bin's weight
    assign gap     = TOTAL_W - rd_data;
    assign lim_src = r_improved ? gap : rd_data;

    // running prefix sum for select
    assign n_cum = r_cum + rd_data;
    assign hit   = (CMP_W'(r_rand) <= CMP_W'(n_cum));

    // one unit moves between the visited bin and the named bin
    assign do_move = (r_cnt != r_idx) && (r_moved < r_limit)
                   && (r_improved ? (rd_data != '0) : (rd_data < FULL_W));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cnt;
        wr_data = r_improved ? (rd_data - 1'b1) : (rd_data + 1'b1);
        if (i_cmd.step && r_func == awbs_pkg::FUNC_UPDATE && do_move) begin
            wr_en = 1'b1;
        end else if (i_cmd.wrback) begin
            wr_en   = 1'b1;
            wr_addr = r_idx;
            wr_data = r_own;
        end
    end

    // weight table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BINS; k++) begin
                r_w[k] <= (k == NUM_BINS - 1) ? LAST_SHARE_W : SHARE_W;
            end
        end else if (wr_en) begin
            r_w[wr_addr] <= wr_data;
        end
    end

    // walk control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_moved     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_cnt   <= '0;
                r_moved <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_func == awbs_pkg::FUNC_UPDATE && do_move) begin
                    r_moved <= r_moved + 1'b1;
                end
                if (r_func == awbs_pkg::FUNC_SELECT && !r_found) begin
                    r_found <= hit;
                end
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func     <= i_func;
            r_idx      <= i_bin_index;
            r_improved <= i_improved;
            r_rand     <= i_rand_value;
            r_cum      <= '0;
        end
        if (i_cmd.load) begin
            r_own   <= rd_data;
            r_limit <= (lim_src > MAX_MOVE_W) ? MAX_MOVE_B : lim_src[BIN_W-1:0];
        end
        if (i_cmd.step) begin
            if (r_func == awbs_pkg::FUNC_SELECT) begin
                r_cum <= n_cum;
                if (!r_found) begin
                    r_res_bin <= r_cnt;
                    r_res_wt  <= rd_data;
                end
            end else if (do_move) begin
                r_own <= r_improved ? (r_own + 1'b1) : (r_own - 1'b1);
            end
        end
        if (i_cmd.fin) begin
            if (r_func == awbs_pkg::FUNC_SELECT) begin
                r_out_bin <= r_res_bin;
                r_out_wt  <= r_res_wt;
            end else begin
                r_out_bin <= r_idx;
                r_out_wt  <= idx_ok ? r_own : '0;
            end
        end
    end

    assign o_stat.is_select = (r_func == awbs_pkg::FUNC_SELECT);
    assign o_stat.idx_ok    = idx_ok;
    assign o_stat.last      = (r_cnt == LAST_BIN);
    assign o_stat.out_free  = !r_out_valid || i_ready;

    assign o_valid      = r_out_valid;
    assign o_chosen_bin = r_out_bin;
    assign o_bin_weight = r_out_wt;

`ifndef SYNTHESIS
    // never more units moved than the limit allows
    a_moved_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && r_func == awbs_pkg::FUNC_UPDATE) |-> (r_moved <= r_limit))
        else $error("move count exceeded the limit");

    // the named bin is written back only for an update of an existing bin
    a_wb_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wrback |-> (r_func == awbs_pkg::FUNC_UPDATE) && idx_ok)
        else $error("write back on a select or an absent bin");

    // a handed-off result is shown next cycle and stays in range
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> o_valid && (o_bin_weight <= TOTAL_W))
        else $error("result lost or out of range after hand-off");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the adaptive weighted bin selector: a local mirror
// of the weight table predicts every result, random traffic on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BINS     = 8;
    localparam int TOTAL_WEIGHT = 256;
    localparam int BIN_W        = 3;
    localparam int WEIGHT_W     = 9;
    localparam int RAND_W       = awbs_pkg::RAND_W;
    localparam int MAX_MOVE     = NUM_BINS - 1;
    localparam int RANDOM_ITEMS = 1050;
    // idle time after the last result before the verdict, as a margin
    localparam int SETTLE_CYCLES = 24;

    // values of the improved flag
    localparam logic REWARD  = 1'b1;
    localparam logic PENALTY = 1'b0;

    typedef struct {
        logic                func;
        logic [BIN_W-1:0]    bin_index;
        logic                improved;
        logic [RAND_W-1:0]   rand_value;
        bit                  drain;      // hold this one back until all results are in
    } t_bin_request;

    typedef struct {
        logic [BIN_W-1:0]    chosen_bin;
        logic [WEIGHT_W-1:0] bin_weight;
    } t_bin_result;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // input channel, known values from time zero
    logic              i_valid      = 1'b0;
    logic              o_ready;
    logic              i_func       = awbs_pkg::FUNC_UPDATE;
    logic [BIN_W-1:0]  i_bin_index  = '0;
    logic              i_improved   = PENALTY;
    logic [RAND_W-1:0] i_rand_value = '0;

    // result channel
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [BIN_W-1:0]    o_chosen_bin;
    logic [WEIGHT_W-1:0] o_bin_weight;

    // stimulus and scoreboard state
    t_bin_request request_q[$];
    t_bin_result  expected_results[$];
    int           weight_mirror[NUM_BINS];
    int           total_requests = 0;
    int           sent_count     = 0;
    int           fail_count     = 0;

    adaptive_weighted_bin_selector #(
        .NUM_BINS     (NUM_BINS),
        .TOTAL_WEIGHT (TOTAL_WEIGHT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_bin_index  (i_bin_index),
        .i_improved   (i_improved),
        .i_rand_value (i_rand_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_chosen_bin (o_chosen_bin),
        .o_bin_weight (o_bin_weight)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // traffic shaping: sender mostly busy and receiver lazy for the first
    // third, the reverse for the second third, full speed for the rest
    function automatic int traffic_stage();
        if (sent_count < total_requests / 3) begin
            return 0;
        end else if (sent_count < (2 * total_requests) / 3) begin
            return 1;
        end
        return 2;
    endfunction

    function automatic int sender_idle_pct();
        case (traffic_stage())
            0:       return 14;
            1:       return 64;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (traffic_stage())
            0:       return 64;
            1:       return 14;
            default: return 0;
        endcase
    endfunction

    // mirror of the weight table: applies one accepted transaction and
    // returns the result the block must produce for it
    task automatic apply_request(input t_bin_request req, output t_bin_result res);
        int lim;
        int moved;
        int cum;
        int sel;
        int b;
        b     = int'(req.bin_index);
        moved = 0;
        if (req.func == awbs_pkg::FUNC_UPDATE) begin
            if (req.improved == REWARD) begin
                // named bin pulls one unit from each nonzero bin, in index order
                lim = TOTAL_WEIGHT - weight_mirror[b];
                if (lim > MAX_MOVE) lim = MAX_MOVE;
                for (int i = 0; i < NUM_BINS && moved < lim; i++) begin
                    if (i != b && weight_mirror[i] != 0) begin
                        weight_mirror[i]--;
                        weight_mirror[b]++;
                        moved++;
                    end
                end
            end else begin
                // named bin hands one unit to each bin that is not yet full
                lim = weight_mirror[b];
                if (lim > MAX_MOVE) lim = MAX_MOVE;
                for (int i = 0; i < NUM_BINS && moved < lim; i++) begin
                    if (i != b && weight_mirror[i] < TOTAL_WEIGHT - 1) begin
                        weight_mirror[i]++;
                        weight_mirror[b]--;
                        moved++;
                    end
                end
            end
            res.chosen_bin = req.bin_index;
            res.bin_weight = WEIGHT_W'(weight_mirror[b]);
        end else begin
            // roulette wheel: first prefix sum at or above the draw,
            // last bin if none gets there
            sel = NUM_BINS - 1;
            cum = 0;
            for (int i = 0; i < NUM_BINS; i++) begin
                cum += weight_mirror[i];
                if (int'(req.rand_value) <= cum) begin
                    sel = i;
                    break;
                end
            end
            res.chosen_bin = BIN_W'(sel);
            res.bin_weight = WEIGHT_W'(weight_mirror[sel]);
        end
    endtask

    task automatic add_request(input int func, input int bin, input int imp, input int draw,
                               input bit drain);
        t_bin_request req;
        req.func       = 1'(func);
        req.bin_index  = BIN_W'(bin);
        req.improved   = 1'(imp);
        req.rand_value = RAND_W'(draw);
        req.drain      = drain;
        request_q.push_back(req);
    endtask

    // mostly nonzero draws, now and then the zero draw
    function automatic int random_draw();
        if ($urandom_range(0, 31) == 0) return 0;
        return $urandom_range(1, 255);
    endfunction

    // driver: presents the queued transactions, holds the payload steady
    // while the block stalls
    always @(posedge i_clk) begin : drive_requests
        t_bin_request head;
        t_bin_result  outcome;
        bit           hold;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                apply_request(request_q[0], outcome);
                expected_results.push_back(outcome);
                void'(request_q.pop_front());
                sent_count++;
            end
            // a transaction still waiting for o_ready keeps valid and payload
            if (!(i_valid && !o_ready)) begin
                hold = (request_q.size() == 0) ||
                       ($urandom_range(0, 99) < sender_idle_pct());
                // drain point: nothing goes out until every result is back
                if (!hold && request_q[0].drain && expected_results.size() != 0) begin
                    hold = 1'b1;
                end
                if (hold) begin
                    i_valid <= 1'b0;
                end else begin
                    head         = request_q[0];
                    i_valid      <= 1'b1;
                    i_func       <= head.func;
                    i_bin_index  <= head.bin_index;
                    i_improved   <= head.improved;
                    i_rand_value <= head.rand_value;
                end
            end
        end
    end

    // monitor: compares each result transaction with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_bin_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: chosen_bin %0d bin_weight %0d",
                           o_chosen_bin, o_bin_weight);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_chosen_bin !== want.chosen_bin) begin
                        $error("chosen_bin mismatch: expected %0d, actual %0d",
                               want.chosen_bin, o_chosen_bin);
                        fail_count++;
                    end
                    if (o_bin_weight !== want.bin_weight) begin
                        $error("bin_weight mismatch: expected %0d, actual %0d",
                               want.bin_weight, o_bin_weight);
                        fail_count++;
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    initial begin : run_test
        int directed_count;
        int mode;
        int bin;
        int burst;
        int pick;

        // reset state of the mirror, remainder goes to the last bin
        for (int i = 0; i < NUM_BINS; i++) begin
            weight_mirror[i] = TOTAL_WEIGHT / NUM_BINS;
        end
        weight_mirror[NUM_BINS - 1] += TOTAL_WEIGHT - (TOTAL_WEIGHT / NUM_BINS) * NUM_BINS;

        // directed: draw extremes and boundaries on the reset table
        add_request(awbs_pkg::FUNC_SELECT, 0, 0, 0,   0);
        add_request(awbs_pkg::FUNC_SELECT, 7, 1, 1,   0);
        add_request(awbs_pkg::FUNC_SELECT, 0, 0, 255, 0);
        add_request(awbs_pkg::FUNC_SELECT, 0, 0, 32,  0);
        add_request(awbs_pkg::FUNC_SELECT, 0, 0, 33,  0);
        // drain bin 0 to zero weight, then the zero draw must still pick it
        repeat (5) add_request(awbs_pkg::FUNC_UPDATE, 0, PENALTY, 0, 0);
        add_request(awbs_pkg::FUNC_SELECT, 0, 0, 0, 0);
        add_request(awbs_pkg::FUNC_SELECT, 0, 0, 1, 0);
        // penalty of an empty bin moves nothing
        add_request(awbs_pkg::FUNC_UPDATE, 0, PENALTY, 0, 0);
        add_request(awbs_pkg::FUNC_UPDATE, 0, REWARD,  0, 0);
        add_request(awbs_pkg::FUNC_UPDATE, 7, REWARD,  255, 0);
        add_request(awbs_pkg::FUNC_UPDATE, 7, PENALTY, 255, 0);
        add_request(awbs_pkg::FUNC_UPDATE, 3, REWARD,  0, 0);
        add_request(awbs_pkg::FUNC_UPDATE, 3, PENALTY, 0, 0);
        add_request(awbs_pkg::FUNC_SELECT, 5, 1, 128, 0);
        add_request(awbs_pkg::FUNC_SELECT, 2, 0, 255, 0);
        directed_count = request_q.size();

        // random: reward runs push one bin toward the full total and starve
        // the others, penalty runs spread weight back out, loose singles
        // cover every field combination
        while (request_q.size() < directed_count + RANDOM_ITEMS) begin
            mode = $urandom_range(0, 99);
            if (mode < 45) begin
                bin   = $urandom_range(0, NUM_BINS - 1);
                burst = $urandom_range(4, 45);
                repeat (burst) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        add_request(awbs_pkg::FUNC_UPDATE, bin, REWARD, $urandom,
                                    $urandom_range(0, 99) == 0);
                    end else if (pick < 80) begin
                        add_request(awbs_pkg::FUNC_UPDATE, $urandom, PENALTY, $urandom,
                                    $urandom_range(0, 99) == 0);
                    end else begin
                        add_request(awbs_pkg::FUNC_SELECT, $urandom, $urandom,
                                    random_draw(), $urandom_range(0, 99) == 0);
                    end
                end
            end else if (mode < 65) begin
                bin   = $urandom_range(0, NUM_BINS - 1);
                burst = $urandom_range(1, 10);
                repeat (burst) begin
                    if ($urandom_range(0, 99) < 60) begin
                        add_request(awbs_pkg::FUNC_UPDATE, bin, PENALTY, $urandom,
                                    $urandom_range(0, 99) == 0);
                    end else begin
                        add_request(awbs_pkg::FUNC_SELECT, $urandom, $urandom,
                                    random_draw(), $urandom_range(0, 99) == 0);
                    end
                end
            end else begin
                add_request($urandom, $urandom, $urandom, $urandom,
                            $urandom_range(0, 99) == 0);
            end
        end

        total_requests = request_q.size();
        // full drain after the directed part and at each traffic change
        request_q[directed_count].drain         = 1'b1;
        request_q[total_requests / 3].drain       = 1'b1;
        request_q[(2 * total_requests) / 3].drain = 1'b1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_count != total_requests) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
